// ===== src/kmrt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the keyed message reassembly table: sizes, field widths, codes
// and the request/response item types. Depends on nothing.
package kmrt_pkg;

	// Table geometry
	localparam int ENTRIES      = 8;
	localparam int BUFFER_BYTES = 2048;
	localparam int KEY_BITS     = 16;

	// Fixed field widths
	localparam int ACTION_W     = 3;
	localparam int MSG_KEY_W    = 16;
	localparam int SIZE_W       = 12;
	localparam int BYTE_W       = 8;
	localparam int OFFSET_W     = 11;
	localparam int STATUS_W     = 3;
	localparam int ACTIVE_W     = 4;
	localparam int COUNT_W      = 32;
	localparam int SIZE_LIMIT_W = 12;
	localparam logic [SIZE_LIMIT_W-1:0] SIZE_LIMIT_RESET = 12'd1600;

	// Derived widths
	localparam int ENTRY_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OFF_W    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam int FILL_W   = OFF_W + 1;
	localparam int KEY_W    = (KEY_BITS < MSG_KEY_W) ? KEY_BITS : MSG_KEY_W;
	localparam int SUM_W    = 13;
	localparam int POP_W    = $clog2(ENTRIES + 1);
	localparam int ADDR_W   = ENTRY_W + OFF_W;
	localparam int MEM_DEPTH = ENTRIES * (1 << OFF_W);

	// Error counters
	localparam int NUM_COUNTERS = 7;
	localparam int CSEL_W       = 3;
	localparam logic [CSEL_W-1:0] CNT_BAD_SIZE    = 3'd0;
	localparam logic [CSEL_W-1:0] CNT_APPEND_MISS = 3'd1;
	localparam logic [CSEL_W-1:0] CNT_OVERFILL    = 3'd2;
	localparam logic [CSEL_W-1:0] CNT_QUERY_MISS  = 3'd3;
	localparam logic [CSEL_W-1:0] CNT_READ_MISS   = 3'd4;
	localparam logic [CSEL_W-1:0] CNT_REMOVE_MISS = 3'd5;
	localparam logic [CSEL_W-1:0] CNT_TABLE_FULL  = 3'd6;

	// Actions
	localparam logic [ACTION_W-1:0] ACT_START   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_APPEND  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_READ    = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_REMOVE  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_COUNTER = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFILL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [ACTION_W-1:0]  action;
		logic [MSG_KEY_W-1:0] msg_key;
		logic [SIZE_W-1:0]    msg_size;
		logic [BYTE_W-1:0]    data_byte;
		logic [SIZE_W-1:0]    chunk_length;
		logic                 chunk_first;
		logic [OFFSET_W-1:0]  read_offset;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                done_flag;
		logic [BYTE_W-1:0]   read_byte;
		logic [ACTIVE_W-1:0] active_entries;
		logic [COUNT_W-1:0]  counter_value;
	} rsp_item_t;

endpackage

// ===== src/kmrt_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the reassembly table: valid/ready plus one request item.
// Depends on kmrt_pkg.
interface kmrt_req_if import kmrt_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== src/kmrt_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel of the reassembly table: valid/ready plus one result item.
// Depends on kmrt_pkg.
interface kmrt_rsp_if import kmrt_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== src/keyed_message_reassembly_table.sv =====
`timescale 1ns / 1ps
// Keyed message reassembly table: up to ENTRIES contexts found by key match,
// bytes kept in one synchronous byte store. Depends on kmrt_pkg, kmrt_req_if, kmrt_rsp_if.
// Flow: a transferred request is latched, executed, then finished into the output
// register once that is free or draining. No new request is taken until the context
// read-modify-write and the byte store read are done; one is taken while a result waits.
// Reset: contexts invalid, counters zero, size limit 1600; byte store not cleared.
module keyed_message_reassembly_table import kmrt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [SIZE_LIMIT_W-1:0] cfg_wdata,
	kmrt_req_if.sink                req,
	kmrt_rsp_if.source              rsp
);

	// Sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;

	// Configuration
	logic [SIZE_LIMIT_W-1:0] size_limit_q;

	// Context table (small, kept in flops for the parallel key compare)
	logic              valid_q   [ENTRIES];
	logic [KEY_W-1:0]  key_q     [ENTRIES];
	logic [FILL_W-1:0] expect_q  [ENTRIES];
	logic [FILL_W-1:0] fill_q    [ENTRIES];
	logic              drop_q    [ENTRIES];

	// Error counters
	logic [COUNT_W-1:0] cnt_q [NUM_COUNTERS];

	// Byte store
	logic [BYTE_W-1:0] mem [MEM_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	// Latched request and result fields waiting for the finish step
	req_item_t          item_q;
	logic [STATUS_W-1:0] status_q;
	logic                done_q;
	logic                rd_sel_q;
	logic [COUNT_W-1:0]  cval_q;

	// Output register
	logic      out_valid_q;
	rsp_item_t out_q;

	// Request decode
	logic [KEY_W-1:0] key_in;
	logic [SUM_W-1:0] exp_ext, clen_ext, roff_ext, limit_ext;
	logic [ENTRIES-1:0] hit_vec;
	logic               hit;
	logic [ENTRY_W-1:0] hit_idx, free_idx, tgt_idx;
	logic               any_free;
	logic [SUM_W-1:0]   fill_ext, expect_ext;

	// Execute outcome
	logic [STATUS_W-1:0] status_n;
	logic                done_n, rd_sel_n, mem_we, mem_re, ent_we;
	logic                bump_en;
	logic [CSEL_W-1:0]   bump_sel;
	logic [COUNT_W-1:0]  cval_n;
	logic                nv_valid, nv_drop;
	logic [FILL_W-1:0]   nv_expect, nv_fill;
	logic [ADDR_W-1:0]   mem_addr;
	logic [POP_W-1:0]    active_cnt;

	logic req_fire, fin_go;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	// Finish only once the output register is free or being drained
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	assign key_in    = item_q.msg_key[KEY_W-1:0];
	assign exp_ext   = SUM_W'(item_q.msg_size);
	assign clen_ext  = SUM_W'(item_q.chunk_length);
	assign roff_ext  = SUM_W'(item_q.read_offset);
	assign limit_ext = SUM_W'(size_limit_q);

	// Parallel key compare; lowest matching and lowest free entry win
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		any_free = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == key_in);
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = ENTRY_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = ENTRY_W'(i);
				any_free = 1'b1;
			end
		end
		hit = |hit_vec;
	end

	assign tgt_idx    = hit ? hit_idx : free_idx;
	assign fill_ext   = SUM_W'(fill_q[tgt_idx]);
	assign expect_ext = SUM_W'(expect_q[tgt_idx]);

	// Decide the effect of the latched request on the context table and counters
	always_comb begin
		status_n  = ST_OK;
		done_n    = 1'b0;
		rd_sel_n  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		ent_we    = 1'b0;
		bump_en   = 1'b0;
		bump_sel  = CNT_BAD_SIZE;
		cval_n    = '0;
		nv_valid  = valid_q[tgt_idx];
		nv_drop   = drop_q[tgt_idx];
		nv_expect = expect_q[tgt_idx];
		nv_fill   = fill_q[tgt_idx];
		mem_addr  = {tgt_idx, fill_q[tgt_idx][OFF_W-1:0]};
		unique case (item_q.action)
			ACT_START: begin
				if (exp_ext > limit_ext || exp_ext > SUM_W'(BUFFER_BYTES)) begin
					status_n = ST_TOO_BIG;
					bump_en  = 1'b1;
					bump_sel = CNT_BAD_SIZE;
				end else if (!hit && !any_free) begin
					status_n = ST_FULL;
					bump_en  = 1'b1;
					bump_sel = CNT_TABLE_FULL;
				end else begin
					ent_we    = 1'b1;
					nv_valid  = 1'b1;
					nv_drop   = 1'b0;
					nv_expect = FILL_W'(item_q.msg_size);
					nv_fill   = '0;
				end
			end
			ACT_APPEND: begin
				if (!hit) begin
					bump_en  = 1'b1;
					bump_sel = CNT_APPEND_MISS;
					status_n = any_free ? ST_UNKNOWN : ST_FULL;
				end else begin
					ent_we = 1'b1;
					if (item_q.chunk_first) begin
						nv_drop = 1'b0;
					end
					priority if (item_q.chunk_first && (fill_ext + clen_ext > expect_ext)) begin
						// chunk cannot fit: drop it whole, count once
						nv_drop  = 1'b1;
						status_n = ST_OVERFILL;
						bump_en  = 1'b1;
						bump_sel = CNT_OVERFILL;
					end else if (!item_q.chunk_first && drop_q[tgt_idx]) begin
						status_n = ST_OVERFILL;
					end else if (fill_ext >= expect_ext || fill_ext >= SUM_W'(BUFFER_BYTES)) begin
						nv_drop  = 1'b1;
						status_n = ST_OVERFILL;
						bump_en  = 1'b1;
						bump_sel = CNT_OVERFILL;
					end else begin
						mem_we  = 1'b1;
						nv_fill = fill_q[tgt_idx] + 1'b1;
					end
				end
			end
			ACT_QUERY: begin
				if (!hit) begin
					status_n = ST_UNKNOWN;
					bump_en  = 1'b1;
					bump_sel = CNT_QUERY_MISS;
				end else begin
					done_n = (fill_q[tgt_idx] == expect_q[tgt_idx]);
				end
			end
			ACT_READ: begin
				mem_addr = {tgt_idx, roff_ext[OFF_W-1:0]};
				if (!hit) begin
					status_n = ST_UNKNOWN;
					bump_en  = 1'b1;
					bump_sel = CNT_READ_MISS;
				end else if (roff_ext < SUM_W'(BUFFER_BYTES)) begin
					mem_re   = 1'b1;
					rd_sel_n = 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (!hit) begin
					status_n = ST_UNKNOWN;
					bump_en  = 1'b1;
					bump_sel = CNT_REMOVE_MISS;
				end else begin
					ent_we   = 1'b1;
					nv_valid = 1'b0;
					nv_drop  = 1'b0;
				end
			end
			ACT_COUNTER: begin
				if (item_q.read_offset < OFFSET_W'(NUM_COUNTERS)) begin
					cval_n = cnt_q[item_q.read_offset[CSEL_W-1:0]];
				end
			end
			default: begin
				// unused actions: no effect
			end
		endcase
	end

	// Count held keys after the execute step has updated the table
	always_comb begin
		active_cnt = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			active_cnt = active_cnt + POP_W'(valid_q[i]);
		end
	end

	// Sequencer: take a request, execute it against the table, then hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (req_fire) begin
					state_q <= S_EXEC;
				end
				S_EXEC: state_q <= S_FIN;
				S_FIN: if (fin_go) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Size limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q <= SIZE_LIMIT_RESET;
		end else if (cfg_we) begin
			size_limit_q <= cfg_wdata;
		end
	end

	// Hold the request payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_q <= req.item;
		end
	end

	// Context control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				drop_q[i]  <= 1'b0;
			end
		end else if (state_q == S_EXEC && ent_we) begin
			valid_q[tgt_idx] <= nv_valid;
			drop_q[tgt_idx]  <= nv_drop;
		end
	end

	// Context payload: only meaningful while the entry is valid
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && ent_we) begin
			key_q[tgt_idx]    <= key_in;
			expect_q[tgt_idx] <= nv_expect;
			fill_q[tgt_idx]   <= nv_fill;
		end
	end

	// Saturating error counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (state_q == S_EXEC && bump_en) begin
			for (int i = 0; i < NUM_COUNTERS; i++) begin
				if (bump_sel == CSEL_W'(i) && cnt_q[i] != '1) begin
					cnt_q[i] <= cnt_q[i] + 1'b1;
				end
			end
		end
	end

	// Byte store: one port, write on append, registered read on read byte
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && mem_we) begin
			mem[mem_addr] <= item_q.data_byte;
		end
		if (state_q == S_EXEC && mem_re) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	// Hold the execute outcome for the finish step
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			status_q <= status_n;
			done_q   <= done_n;
			rd_sel_q <= rd_sel_n;
			cval_q   <= cval_n;
		end
	end

	// Output register: load on finish, drop valid once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q.status         <= status_q;
			out_q.done_flag      <= done_q;
			out_q.read_byte      <= rd_sel_q ? rd_data_q : '0;
			out_q.active_entries <= ACTIVE_W'(active_cnt);
			out_q.counter_value  <= cval_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.item  = out_q;

endmodule
